### rtl/cdds_pkg.sv
// shared types, constants and month-length function for the date stepper
package cdds_pkg;

    localparam int DAY_W         = 5;
    localparam int MONTH_W       = 4;
    localparam int YEAR_W        = 14;
    localparam int COUNT_IN_W    = 16;

    localparam int YEAR_MAX_DEF    = 9999;
    localparam int COUNT_WIDTH_DEF = 16;

    // stream packing
    localparam int DAY_LSB    = 0;
    localparam int MONTH_LSB  = DAY_LSB + DAY_W;
    localparam int YEAR_LSB   = MONTH_LSB + MONTH_W;
    localparam int COUNT_LSB  = YEAR_LSB + YEAR_W;
    localparam int S_FIELD_W  = COUNT_LSB + COUNT_IN_W;
    localparam int S_TDATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W  = YEAR_LSB + YEAR_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 2;
    localparam int M_TUSER_W  = 4;

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [DAY_W-1:0] LEN_LONG  = DAY_W'(31);
    localparam logic [DAY_W-1:0] LEN_SHORT = DAY_W'(30);
    localparam logic [DAY_W-1:0] LEN_LEAP  = DAY_W'(29);
    localparam logic [DAY_W-1:0] LEN_FEB   = DAY_W'(28);

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_CMP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_INVALID   = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REL_EQUAL   = 2'd0,
        REL_LESS    = 2'd1,
        REL_GREATER = 2'd2
    } rel_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // leap year: year divisible by 4
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic [YEAR_W-1:0] year);
        logic [DAY_W-1:0] len;
        case (month)
            MONTH_FEB: len = (year[1:0] == 2'b00) ? LEN_LEAP : LEN_FEB;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: len = LEN_SHORT;
            default:   len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

### rtl/cdds_date_walker.sv
// iterative add/subtract of a day count, one month per cycle
module cdds_date_walker #(
    parameter int YEAR_MAX = cdds_pkg::YEAR_MAX_DEF,
    parameter int COUNT_W  = cdds_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 sub_mode,
    input  logic [COUNT_W-1:0]   count,
    input  cdds_pkg::date_t      date_in,
    output logic                 done,
    output cdds_pkg::date_t      date_out,
    output cdds_pkg::status_t    status
);
    import cdds_pkg::*;

    localparam int CNT_W = (COUNT_W > DAY_W) ? COUNT_W : DAY_W;
    localparam logic [YEAR_W-1:0] YEAR_TOP = YEAR_W'(YEAR_MAX);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                sub_reg, sub_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    date_t               date_reg, date_next;
    status_t             status_reg, status_next;

    logic [DAY_W-1:0]    len;
    logic [DAY_W-1:0]    rem;
    logic [CNT_W-1:0]    rem_ext;
    logic [CNT_W-1:0]    day_ext;
    logic [MONTH_W-1:0]  month_dec;

    always_comb
    begin
        len       = month_len(date_reg.month, date_reg.year);
        rem       = len - date_reg.day;
        rem_ext   = CNT_W'(rem);
        day_ext   = CNT_W'(date_reg.day);
        month_dec = date_reg.month - MONTH_W'(1);

        busy_next   = busy_reg;
        done_next   = 1'b0;
        sub_next    = sub_reg;
        n_next      = n_reg;
        date_next   = date_reg;
        status_next = status_reg;

        if (start)
        begin
            busy_next = 1'b1;
            sub_next  = sub_mode;
            n_next    = CNT_W'(count);
            date_next = date_in;
        end
        else if (busy_reg)
        begin
            if (!sub_reg)
            begin
                if (n_reg <= rem_ext)
                begin
                    date_next.day = date_reg.day + n_reg[DAY_W-1:0];
                    busy_next     = 1'b0;
                    done_next     = 1'b1;
                    status_next   = STAT_OK;
                end
                else
                begin
                    n_next        = n_reg - rem_ext - CNT_W'(1);
                    date_next.day = DAY_W'(1);
                    if (date_reg.month == MONTH_DEC)
                    begin
                        if (date_reg.year >= YEAR_TOP)
                        begin
                            busy_next   = 1'b0;
                            done_next   = 1'b1;
                            status_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            date_next.month = MONTH_JAN;
                            date_next.year  = date_reg.year + YEAR_W'(1);
                        end
                    end
                    else
                    begin
                        date_next.month = date_reg.month + MONTH_W'(1);
                    end
                end
            end
            else
            begin
                if (n_reg < day_ext)
                begin
                    date_next.day = date_reg.day - n_reg[DAY_W-1:0];
                    busy_next     = 1'b0;
                    done_next     = 1'b1;
                    status_next   = STAT_OK;
                end
                else
                begin
                    n_next = n_reg - day_ext;
                    if (date_reg.month == MONTH_JAN)
                    begin
                        if (date_reg.year == '0)
                        begin
                            busy_next   = 1'b0;
                            done_next   = 1'b1;
                            status_next = STAT_UNDERFLOW;
                        end
                        else
                        begin
                            // december always has the long length
                            date_next.year  = date_reg.year - YEAR_W'(1);
                            date_next.month = MONTH_DEC;
                            date_next.day   = LEN_LONG;
                        end
                    end
                    else
                    begin
                        date_next.month = month_dec;
                        date_next.day   = month_len(month_dec, date_reg.year);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg    <= sub_next;
        n_reg      <= n_next;
        date_reg   <= date_next;
        status_reg <= status_next;
    end

    assign done     = done_reg;
    assign date_out = date_reg;
    assign status   = status_reg;

endmodule

### rtl/calendar_date_day_stepper.sv
// calendar date holder with load, add days, subtract days and compare
//
//  channel  dir  signals                      contents
//  s_*      in   tvalid tready tdata tuser    one operation item
//  m_*      out  tvalid tready tdata tuser    held date, status and relation
//
// load and compare: result registered in the cycle after the item is taken
// add and subtract: the walker moves one month per cycle until the count is used up
//   or the year range is left, and the result is registered when it stops
// one item at a time; s_tready is low while the walker runs
// s_tready is also low while a finished result waits and m_tready is low
// reset sets the held date to 1 january of year 0
module calendar_date_day_stepper #(
    parameter int YEAR_MAX    = cdds_pkg::YEAR_MAX_DEF,
    parameter int COUNT_WIDTH = cdds_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cdds_pkg::S_TDATA_W-1:0]  s_tdata,   // day_in, month_in, year_in, day_count
    input  logic [cdds_pkg::S_TUSER_W-1:0]  s_tuser,   // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cdds_pkg::M_TDATA_W-1:0]  m_tdata,   // day_out, month_out, year_out
    output logic [cdds_pkg::M_TUSER_W-1:0]  m_tuser    // status, relation
);
    import cdds_pkg::*;

    localparam int NW = (COUNT_WIDTH < COUNT_IN_W) ? COUNT_WIDTH : COUNT_IN_W;
    localparam logic [YEAR_W-1:0] YEAR_TOP = YEAR_W'(YEAR_MAX);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t              state_reg, state_next;
    date_t               held_reg, held_next;
    logic                out_valid_reg, out_valid_next;
    date_t               out_date_reg, out_date_next;
    status_t             out_status_reg, out_status_next;
    rel_t                out_rel_reg, out_rel_next;

    logic                s_accept;
    op_t                 in_op;
    date_t               in_date;
    logic [NW-1:0]       in_count;
    logic                load_ok;
    rel_t                cmp_rel;

    logic                walk_start;
    logic                walk_done;
    date_t               walk_date;
    status_t             walk_status;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign in_op         = op_t'(s_tuser);
    assign in_date.day   = s_tdata[DAY_LSB +: DAY_W];
    assign in_date.month = s_tdata[MONTH_LSB +: MONTH_W];
    assign in_date.year  = s_tdata[YEAR_LSB +: YEAR_W];
    assign in_count      = s_tdata[COUNT_LSB +: NW];

    always_comb
    begin
        load_ok = (in_date.month >= MONTH_JAN) && (in_date.month <= MONTH_DEC)
               && (in_date.year <= YEAR_TOP) && (in_date.day != '0)
               && (in_date.day <= month_len(in_date.month, in_date.year));

        if (held_reg.year != in_date.year)
            cmp_rel = (held_reg.year < in_date.year) ? REL_LESS : REL_GREATER;
        else if (held_reg.month != in_date.month)
            cmp_rel = (held_reg.month < in_date.month) ? REL_LESS : REL_GREATER;
        else if (held_reg.day != in_date.day)
            cmp_rel = (held_reg.day < in_date.day) ? REL_LESS : REL_GREATER;
        else
            cmp_rel = REL_EQUAL;
    end

    cdds_date_walker #(
        .YEAR_MAX (YEAR_MAX),
        .COUNT_W  (NW)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (walk_start),
        .sub_mode (in_op == OP_SUB),
        .count    (in_count),
        .date_in  (held_reg),
        .done     (walk_done),
        .date_out (walk_date),
        .status   (walk_status)
    );

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg;
        out_date_next   = out_date_reg;
        out_status_next = out_status_reg;
        out_rel_next    = out_rel_reg;
        walk_start      = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_op)
                        OP_LOAD:
                        begin
                            if (load_ok)
                                held_next = in_date;
                            out_valid_next  = 1'b1;
                            out_date_next   = held_next;
                            out_status_next = load_ok ? STAT_OK : STAT_INVALID;
                            out_rel_next    = REL_EQUAL;
                        end
                        OP_CMP:
                        begin
                            out_valid_next  = 1'b1;
                            out_date_next   = held_reg;
                            out_status_next = STAT_OK;
                            out_rel_next    = cmp_rel;
                        end
                        default:
                        begin
                            walk_start = 1'b1;
                            state_next = ST_WALK;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    // a failed step leaves the held date as it was
                    if (walk_status == STAT_OK)
                        held_next = walk_date;
                    out_valid_next  = 1'b1;
                    out_date_next   = held_next;
                    out_status_next = walk_status;
                    out_rel_next    = REL_EQUAL;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '{year: '0, month: MONTH_JAN, day: DAY_W'(1)};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_date_reg   <= out_date_next;
        out_status_reg <= out_status_next;
        out_rel_reg    <= out_rel_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_date_reg.year, out_date_reg.month, out_date_reg.day});
    assign m_tuser  = {out_rel_reg, out_status_reg};

    // a step item blocks the input until its result is made
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (in_op == OP_ADD || in_op == OP_SUB)) |=> !s_tready)
        else $error("input taken while a day step is pending");

    // the held month stays a real month
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg.month >= MONTH_JAN) && (held_reg.month <= MONTH_DEC))
        else $error("held month out of range");

    // a failed step keeps the held date
    assert property (@(posedge clk) disable iff (!rst_n)
        (walk_done && walk_status != STAT_OK) |=> (held_reg == $past(held_reg)))
        else $error("held date changed by a failed step");

    // walker finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        walk_done |-> (state_reg == ST_WALK))
        else $error("walker done outside a step");

endmodule
